### hdl/trq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trq_pkg: shared types and constants
// Sizes, request codes and the command/status bundles between the
// controller and the datapath of the task ready queue.
// ----------------------------------------------------------------------------
package trq_pkg;

  localparam int READY_DEPTH = 16;
  localparam int TIMER_SLOTS = 8;
  localparam int ID_BITS     = 8;
  localparam int DELAY_BITS  = 32;

  localparam int QI_W = $clog2(READY_DEPTH + 1);
  localparam int QA_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int SI_W = $clog2(TIMER_SLOTS + 1);
  localparam int SA_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [2:0] {
    REQ_ADD      = 3'd0,
    REQ_ADD_DLY  = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_TICK     = 3'd3,
    REQ_DISPATCH = 3'd4,
    REQ_PEEK     = 3'd5,
    REQ_RSVD6    = 3'd6,
    REQ_RSVD7    = 3'd7
  } req_t;

  typedef struct packed {
    logic latch;
    logic qi_clr;
    logic qi_inc;
    logic si_clr;
    logic si_inc;
    logic pid_slot;
    logic push;
    logic slot_write;
    logic slot_clear;
    logic slot_dec;
    logic shift;
    logic set_accept;
    logic set_disp;
    logic set_delayed;
    logic set_ready;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic id_zero;
    logic pid_zero;
    logic q_end;
    logic q_full;
    logic q_empty;
    logic q_hit_pid;
    logic q_hit_id;
    logic shift_last;
    logic s_end;
    logic s_task_zero;
    logic s_cd_zero;
    logic s_hit_id;
  } sts_t;

endpackage

### hdl/task_ready_queue_with_delay_timers_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_ready_queue_with_delay_timers_unit: hardware task scheduler
// Ready FIFO of unique task ids plus a table of delay slots with countdowns.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_type, task_id, delay_ticks) is taken at a rising
//   edge where start is high and busy is low. busy stays high while the
//   request is served; one result beat then appears for exactly one cycle,
//   marked by done, and busy is already low in that cycle so the next
//   start may be taken at the same edge. The receiver cannot stall results.
// Sequencing:
//   Every request scans the delay slots and the ready queue one entry per
//   cycle for the status report. Delete adds a slot sweep, a queue search
//   and a one-entry-per-cycle compaction. A tick visits every slot; each
//   expired slot runs a queue duplicate scan. The queue and the slots are
//   single-ported and scanned in turn; one request is served at a time.
// Reset:
//   Synchronous rst empties the queue, frees every slot, clears the
//   countdowns and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module task_ready_queue_with_delay_timers_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [7:0]  task_id,
  input  logic [31:0] delay_ticks,
  output logic        done,
  output logic        accepted,
  output logic [7:0]  dispatched_id,
  output logic        is_ready,
  output logic        is_delayed,
  output logic [31:0] remaining_ticks,
  output logic        queue_empty
);

  // Command and status bundles between the sequencer and the storage.
  trq_pkg::cmd_t cmd;
  trq_pkg::sts_t sts;

  // The controller decides the scan order of each request.
  trq_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  // The datapath owns the queue, the slots and the result fields, which
  // hold steady through the done cycle.
  trq_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req_type),
    .task_id         (task_id),
    .delay_ticks     (delay_ticks),
    .accepted        (accepted),
    .dispatched_id   (dispatched_id),
    .is_ready        (is_ready),
    .is_delayed      (is_delayed),
    .remaining_ticks (remaining_ticks),
    .queue_empty     (queue_empty)
  );

endmodule

### hdl/trq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trq_datapath: queue, timer slots and result registers
// Holds the ready queue, the delay slots, the scan indices and the result
// fields, and carries out one command bundle per cycle.
// ----------------------------------------------------------------------------
module trq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  trq_pkg::cmd_t                   cmd,
  output trq_pkg::sts_t                   sts,
  input  logic [2:0]                      req_type,
  input  logic [7:0]                      task_id,
  input  logic [31:0]                     delay_ticks,
  output logic                            accepted,
  output logic [7:0]                      dispatched_id,
  output logic                            is_ready,
  output logic                            is_delayed,
  output logic [31:0]                     remaining_ticks,
  output logic                            queue_empty
);

  logic [trq_pkg::ID_BITS-1:0]    fifo  [trq_pkg::READY_DEPTH];
  logic [trq_pkg::ID_BITS-1:0]    stask [trq_pkg::TIMER_SLOTS];
  logic [trq_pkg::DELAY_BITS-1:0] scd   [trq_pkg::TIMER_SLOTS];
  logic [trq_pkg::QI_W-1:0]       count;
  logic [trq_pkg::QI_W-1:0]       qi;
  logic [trq_pkg::SI_W-1:0]       si;
  trq_pkg::req_t                  req;
  logic [trq_pkg::ID_BITS-1:0]    id;
  logic [trq_pkg::ID_BITS-1:0]    pid;
  logic [trq_pkg::DELAY_BITS-1:0] delay;

  logic [trq_pkg::QI_W-1:0]       qi_p1;
  logic [trq_pkg::QA_W-1:0]       qa;
  logic [trq_pkg::QA_W-1:0]       qa_p1;
  logic [trq_pkg::SA_W-1:0]       sa;
  logic [trq_pkg::QA_W-1:0]       ca;

  assign qi_p1 = qi + 1'b1;
  assign qa    = qi[trq_pkg::QA_W-1:0];
  assign qa_p1 = qi_p1[trq_pkg::QA_W-1:0];
  assign sa    = si[trq_pkg::SA_W-1:0];
  assign ca    = count[trq_pkg::QA_W-1:0];

  always_comb begin
    sts.req         = req;
    sts.id_zero     = (id == '0);
    sts.pid_zero    = (pid == '0);
    sts.q_end       = (qi == count);
    sts.q_full      = (count == trq_pkg::QI_W'(trq_pkg::READY_DEPTH));
    sts.q_empty     = (count == '0);
    sts.q_hit_pid   = (fifo[qa] == pid);
    sts.q_hit_id    = (fifo[qa] == id);
    sts.shift_last  = (qi_p1 >= count);
    sts.s_end       = (si == trq_pkg::SI_W'(trq_pkg::TIMER_SLOTS));
    sts.s_task_zero = (stask[sa] == '0);
    sts.s_cd_zero   = (scd[sa] == '0);
    sts.s_hit_id    = (stask[sa] == id);
  end

  assign queue_empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < trq_pkg::READY_DEPTH; i++) fifo[i] <= '0;
      for (int i = 0; i < trq_pkg::TIMER_SLOTS; i++) begin
        stask[i] <= '0;
        scd[i]   <= '0;
      end
    end else begin
      if (cmd.push) begin
        fifo[ca] <= pid;
        count    <= count + 1'b1;
      end
      if (cmd.shift) begin
        if (!sts.shift_last) begin
          fifo[qa] <= fifo[qa_p1];
        end else begin
          fifo[qa] <= '0;
          count    <= count - 1'b1;
        end
      end
      if (cmd.slot_write) begin
        stask[sa] <= id;
        scd[sa]   <= delay;
      end
      if (cmd.slot_clear) begin
        stask[sa] <= '0;
        scd[sa]   <= '0;
      end
      if (cmd.slot_dec) scd[sa] <= scd[sa] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req             <= trq_pkg::req_t'(req_type);
      id              <= task_id[trq_pkg::ID_BITS-1:0];
      pid             <= task_id[trq_pkg::ID_BITS-1:0];
      delay           <= delay_ticks;
      accepted        <= 1'b0;
      dispatched_id   <= '0;
      is_ready        <= 1'b0;
      is_delayed      <= 1'b0;
      remaining_ticks <= '0;
    end
    if (cmd.pid_slot) pid <= stask[sa];
    if (cmd.set_accept) accepted <= 1'b1;
    if (cmd.set_disp) dispatched_id <= 8'(fifo[0]);
    if (cmd.set_ready) is_ready <= 1'b1;
    if (cmd.set_delayed) begin
      is_delayed      <= 1'b1;
      remaining_ticks <= scd[sa];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.latch || cmd.qi_clr) qi <= '0;
    else if (cmd.qi_inc || (cmd.shift && !sts.shift_last)) qi <= qi_p1;
    if (rst || cmd.latch || cmd.si_clr) si <= '0;
    else if (cmd.si_inc) si <= si + 1'b1;
  end

endmodule

### hdl/trq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trq_controller: request sequencer
// Steps through the queue and slot scans of one request and raises the
// result strobe when the status fields are complete.
// ----------------------------------------------------------------------------
module trq_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output trq_pkg::cmd_t cmd,
  input  trq_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PSCAN, S_ADSCAN, S_DSLOT, S_DQSCAN, S_SHIFT,
    S_TSLOT, S_STSLOT, S_STQ, S_DONE
  } state_t;

  state_t state, state_next;
  logic   from_tick, from_tick_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    from_tick_next = from_tick;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          trq_pkg::REQ_ADD: begin
            from_tick_next = 1'b0;
            state_next     = S_PSCAN;
          end
          trq_pkg::REQ_ADD_DLY: state_next = sts.id_zero ? S_STSLOT : S_ADSCAN;
          trq_pkg::REQ_DELETE:  state_next = sts.id_zero ? S_STSLOT : S_DSLOT;
          trq_pkg::REQ_TICK: begin
            from_tick_next = 1'b1;
            state_next     = S_TSLOT;
          end
          trq_pkg::REQ_DISPATCH: begin
            if (sts.q_empty) begin
              state_next = S_STSLOT;
            end else begin
              cmd.set_disp = 1'b1;
              state_next   = S_SHIFT;
            end
          end
          default: state_next = S_STSLOT;
        endcase
      end
      S_PSCAN: begin
        if (sts.pid_zero) begin
          cmd.qi_clr = 1'b1;
          cmd.si_clr = !from_tick;
          cmd.si_inc = from_tick;
          state_next = from_tick ? S_TSLOT : S_STSLOT;
        end else if (sts.q_end || sts.q_hit_pid) begin
          cmd.push       = sts.q_end && !sts.q_full;
          cmd.set_accept = sts.q_end && !sts.q_full && !from_tick;
          cmd.qi_clr     = 1'b1;
          cmd.si_clr     = !from_tick;
          cmd.si_inc     = from_tick;
          state_next     = from_tick ? S_TSLOT : S_STSLOT;
        end else begin
          cmd.qi_inc = 1'b1;
        end
      end
      S_ADSCAN: begin
        if (sts.s_end) begin
          cmd.si_clr = 1'b1;
          state_next = S_STSLOT;
        end else if (sts.s_hit_id || sts.s_task_zero) begin
          cmd.slot_write = 1'b1;
          cmd.set_accept = 1'b1;
          cmd.si_clr     = 1'b1;
          state_next     = S_STSLOT;
        end else begin
          cmd.si_inc = 1'b1;
        end
      end
      S_DSLOT: begin
        if (sts.s_end) begin
          cmd.qi_clr = 1'b1;
          state_next = S_DQSCAN;
        end else begin
          cmd.slot_clear = sts.s_hit_id;
          cmd.si_inc     = 1'b1;
        end
      end
      S_DQSCAN: begin
        if (sts.q_end) begin
          cmd.qi_clr = 1'b1;
          cmd.si_clr = 1'b1;
          state_next = S_STSLOT;
        end else if (sts.q_hit_id) begin
          state_next = S_SHIFT;
        end else begin
          cmd.qi_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) begin
          cmd.qi_clr = 1'b1;
          cmd.si_clr = 1'b1;
          state_next = S_STSLOT;
        end
      end
      S_TSLOT: begin
        if (sts.s_end) begin
          cmd.si_clr = 1'b1;
          cmd.qi_clr = 1'b1;
          state_next = S_STSLOT;
        end else if (sts.s_task_zero) begin
          cmd.si_inc = 1'b1;
        end else if (sts.s_cd_zero) begin
          // Expired slot: free it and run the duplicate check for its task.
          cmd.pid_slot   = 1'b1;
          cmd.slot_clear = 1'b1;
          cmd.qi_clr     = 1'b1;
          state_next     = S_PSCAN;
        end else begin
          cmd.slot_dec = 1'b1;
          cmd.si_inc   = 1'b1;
        end
      end
      S_STSLOT: begin
        if (sts.id_zero || sts.s_end) begin
          state_next = S_STQ;
        end else if (sts.s_hit_id) begin
          cmd.set_delayed = 1'b1;
          state_next      = S_STQ;
        end else begin
          cmd.si_inc = 1'b1;
        end
      end
      S_STQ: begin
        if (sts.id_zero || sts.q_end) begin
          state_next = S_DONE;
        end else if (sts.q_hit_id) begin
          cmd.set_ready = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.qi_inc = 1'b1;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      from_tick <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      from_tick <= from_tick_next;
      done      <= (state == S_DONE);
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DECODE))
    else $error("accepted request did not enter decode");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE))
    else $error("result strobe without done state");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the task ready queue with delay timers
// Drives request beats with random gaps. A scheduler model inside a small
// scoreboard class predicts every status beat, and each done beat is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic        accepted;
    logic [7:0]  dispatched_id;
    logic        is_ready;
    logic        is_delayed;
    logic [31:0] remaining_ticks;
    logic        queue_empty;
  } status_t;

  // Scheduler model plus the queue of status beats still owed by the block.
  class sched_board;
    logic [trq_pkg::ID_BITS-1:0]    fifo[trq_pkg::READY_DEPTH];
    int                             fill;
    logic [trq_pkg::ID_BITS-1:0]    slot_id[trq_pkg::TIMER_SLOTS];
    logic [trq_pkg::DELAY_BITS-1:0] slot_cd[trq_pkg::TIMER_SLOTS];
    status_t                        owed[$];
    int                             errors;

    function new();
      for (int i = 0; i < trq_pkg::READY_DEPTH; i++) fifo[i] = '0;
      for (int i = 0; i < trq_pkg::TIMER_SLOTS; i++) begin
        slot_id[i] = '0;
        slot_cd[i] = '0;
      end
      fill = 0;
      errors = 0;
    endfunction

    function bit queued(logic [trq_pkg::ID_BITS-1:0] id);
      if (id == 0) return 0;
      for (int i = 0; i < fill; i++) if (fifo[i] == id) return 1;
      return 0;
    endfunction

    function bit enqueue(logic [trq_pkg::ID_BITS-1:0] id);
      if (id == 0 || queued(id) || fill >= trq_pkg::READY_DEPTH) return 0;
      fifo[fill] = id;
      fill++;
      return 1;
    endfunction

    function void drop_at(int pos);
      for (int i = pos; i + 1 < fill; i++) fifo[i] = fifo[i+1];
      fill--;
      fifo[fill] = '0;
    endfunction

    // Apply one accepted request and queue the status beat it must produce.
    function void note_request(trq_pkg::req_t req, logic [7:0] tid, logic [31:0] dly);
      status_t s;
      logic [trq_pkg::ID_BITS-1:0] id;
      id = tid[trq_pkg::ID_BITS-1:0];
      s = '{accepted: 1'b0, dispatched_id: 8'd0, is_ready: 1'b0, is_delayed: 1'b0,
            remaining_ticks: 32'd0, queue_empty: 1'b0};
      case (req)
        trq_pkg::REQ_ADD: s.accepted = enqueue(id);
        trq_pkg::REQ_ADD_DLY: begin
          if (id != 0) begin
            for (int i = 0; i < trq_pkg::TIMER_SLOTS; i++) begin
              if (slot_id[i] == id || slot_id[i] == 0) begin
                slot_id[i] = id;
                slot_cd[i] = dly;
                s.accepted = 1'b1;
                break;
              end
            end
          end
        end
        trq_pkg::REQ_DELETE: begin
          if (id != 0) begin
            for (int i = 0; i < trq_pkg::TIMER_SLOTS; i++) begin
              if (slot_id[i] == id) begin
                slot_id[i] = '0;
                slot_cd[i] = '0;
              end
            end
            for (int i = 0; i < fill; i++) begin
              if (fifo[i] == id) begin
                drop_at(i);
                break;
              end
            end
          end
        end
        trq_pkg::REQ_TICK: begin
          for (int i = 0; i < trq_pkg::TIMER_SLOTS; i++) begin
            if (slot_id[i] != 0) begin
              if (slot_cd[i] == 0) begin
                void'(enqueue(slot_id[i]));
                slot_id[i] = '0;
              end else begin
                slot_cd[i]--;
              end
            end
          end
        end
        trq_pkg::REQ_DISPATCH: begin
          if (fill > 0) begin
            s.dispatched_id = fifo[0];
            drop_at(0);
          end
        end
        default: ;
      endcase
      if (id != 0) begin
        for (int i = 0; i < trq_pkg::TIMER_SLOTS; i++) begin
          if (slot_id[i] == id) begin
            s.is_delayed = 1'b1;
            s.remaining_ticks = slot_cd[i];
            break;
          end
        end
      end
      s.is_ready = queued(id);
      s.queue_empty = (fill == 0);
      owed.push_back(s);
    endfunction

    function void check_result(status_t got);
      status_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected status beat", $time);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $time, want.accepted, got.accepted);
        errors++;
      end
      if (got.dispatched_id !== want.dispatched_id) begin
        $display("%0t: dispatched_id exp %0d got %0d", $time,
                 want.dispatched_id, got.dispatched_id);
        errors++;
      end
      if (got.is_ready !== want.is_ready) begin
        $display("%0t: is_ready exp %0d got %0d", $time, want.is_ready, got.is_ready);
        errors++;
      end
      if (got.is_delayed !== want.is_delayed) begin
        $display("%0t: is_delayed exp %0d got %0d", $time,
                 want.is_delayed, got.is_delayed);
        errors++;
      end
      if (got.remaining_ticks !== want.remaining_ticks) begin
        $display("%0t: remaining_ticks exp %0d got %0d", $time,
                 want.remaining_ticks, got.remaining_ticks);
        errors++;
      end
      if (got.queue_empty !== want.queue_empty) begin
        $display("%0t: queue_empty exp %0d got %0d", $time,
                 want.queue_empty, got.queue_empty);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  req_type;
  logic [7:0]  task_id;
  logic [31:0] delay_ticks;
  logic        done;
  logic        accepted;
  logic [7:0]  dispatched_id;
  logic        is_ready;
  logic        is_delayed;
  logic [31:0] remaining_ticks;
  logic        queue_empty;

  sched_board board;
  int         cycles;

  task_ready_queue_with_delay_timers_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .task_id        (task_id),
    .delay_ticks    (delay_ticks),
    .done           (done),
    .accepted       (accepted),
    .dispatched_id  (dispatched_id),
    .is_ready       (is_ready),
    .is_delayed     (is_delayed),
    .remaining_ticks(remaining_ticks),
    .queue_empty    (queue_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung sequencer must not stall the run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Status beats last a single cycle, so every done edge is checked here.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_result('{accepted: accepted, dispatched_id: dispatched_id,
                           is_ready: is_ready, is_delayed: is_delayed,
                           remaining_ticks: remaining_ticks,
                           queue_empty: queue_empty});
    end
  end

  // Send one request beat. The idle gap is drawn per beat; with no gap,
  // start simply stays high so back-to-back beats never toggle it.
  task automatic send_request(trq_pkg::req_t req, logic [7:0] id, logic [31:0] dly);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= req;
    task_id     <= id;
    delay_ticks <= dly;
    @(posedge clk);
    while (!(start && !busy)) @(posedge clk);
    board.note_request(req, id, dly);
  endtask

  // Random request. Ids come mostly from a small pool so that duplicates,
  // full queues and shared slots are hit often; the rest span all 8 bits.
  task automatic send_random(int add_bias);
    int            r;
    trq_pkg::req_t req;
    logic [7:0]    id;
    logic [31:0]   dly;
    r = $urandom_range(0, 99);
    if (r < 25 + add_bias) req = trq_pkg::REQ_ADD;
    else if (r < 45 + add_bias) req = trq_pkg::REQ_ADD_DLY;
    else if (r < 55 + add_bias) req = trq_pkg::REQ_DELETE;
    else if (r < 75 + add_bias) req = trq_pkg::REQ_TICK;
    else if (r < 92 + add_bias / 2) req = trq_pkg::REQ_DISPATCH;
    else req = trq_pkg::req_t'($urandom_range(5, 7));
    r = $urandom_range(0, 99);
    if (r < 70) id = 8'($urandom_range(1, 20));
    else if (r < 78) id = 8'd0;
    else id = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 60) dly = $urandom_range(0, 3);
    else if (r < 85) dly = $urandom_range(0, 20);
    else dly = $urandom;
    send_request(req, id, dly);
  endtask

  initial begin
    board       = new();
    cycles      = 0;
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = 3'd0;
    task_id     = 8'd0;
    delay_ticks = 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty queue, id extremes, every request code, id zero,
    // duplicates, expiry on a zero countdown and the lower-free-slot rule.
    send_request(trq_pkg::REQ_DISPATCH, 8'd0, 32'd0);
    send_request(trq_pkg::REQ_PEEK, 8'd255, 32'd0);
    send_request(trq_pkg::REQ_ADD, 8'd0, 32'd0);
    send_request(trq_pkg::REQ_ADD, 8'd255, 32'd0);
    send_request(trq_pkg::REQ_ADD, 8'd255, 32'd0);
    send_request(trq_pkg::REQ_ADD, 8'd1, 32'd0);
    send_request(trq_pkg::REQ_ADD_DLY, 8'd0, 32'hFFFF_FFFF);
    send_request(trq_pkg::REQ_ADD_DLY, 8'd7, 32'hFFFF_FFFF);
    send_request(trq_pkg::REQ_ADD_DLY, 8'd9, 32'd0);
    send_request(trq_pkg::REQ_ADD_DLY, 8'd255, 32'd1);
    send_request(trq_pkg::REQ_TICK, 8'd7, 32'd0);
    send_request(trq_pkg::REQ_TICK, 8'd255, 32'd0);
    send_request(trq_pkg::REQ_RSVD6, 8'd9, 32'hFFFF_FFFF);
    send_request(trq_pkg::REQ_RSVD7, 8'd255, 32'd5);
    send_request(trq_pkg::REQ_DELETE, 8'd0, 32'd0);
    // Free slot 0, then re-arm id 4: it lands low while slot 1 still holds it.
    send_request(trq_pkg::REQ_ADD_DLY, 8'd4, 32'd3);
    send_request(trq_pkg::REQ_DELETE, 8'd7, 32'd0);
    send_request(trq_pkg::REQ_ADD_DLY, 8'd4, 32'd8);
    send_request(trq_pkg::REQ_DELETE, 8'd1, 32'd0);
    send_request(trq_pkg::REQ_DISPATCH, 8'd255, 32'd0);
    send_request(trq_pkg::REQ_DISPATCH, 8'd9, 32'd0);
    send_request(trq_pkg::REQ_DELETE, 8'd4, 32'd0);

    // Random part. Some stretches lean on adds to fill the queue and slots
    // until both run full; others lean on dispatch and delete to drain.
    for (int n = 0; n < 1850; n++) begin
      if (n == 900) begin
        // Let the block drain completely before carrying on.
        start <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
      end
      if ((n / 150) % 3 == 0) send_random(15);
      else if ((n / 150) % 3 == 1) send_random(-10);
      else send_random(0);
    end
    start <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
